FILE: src/lsog_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsog_pkg
// Shared types and codes for the load switch overcurrent guard.
// ----------------------------------------------------------------------------
package lsog_pkg;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [2:0] ST_OFF     = 3'd0;
  localparam logic [2:0] ST_ON      = 3'd1;
  localparam logic [2:0] ST_OPEN    = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_SOFT_OC = 3'd4;
  localparam logic [2:0] ST_LATCHED = 3'd5;

  localparam logic [1:0] BEH_NONE  = 2'd0;
  localparam logic [1:0] BEH_LATCH = 2'd1;
  localparam logic [1:0] BEH_RETRY = 2'd2;

  localparam logic [2:0] REG_OC_ENABLE    = 3'd0;
  localparam logic [2:0] REG_OC_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_OC_TRIP      = 3'd2;
  localparam logic [2:0] REG_RETRY_LIMIT  = 3'd3;
  localparam logic [2:0] REG_RETRY_DELAY  = 3'd4;
  localparam logic [2:0] REG_ERR_BEHAVIOR = 3'd5;
  localparam logic [2:0] REG_OPEN_LOAD    = 3'd6;
  localparam logic [2:0] REG_FAULT_LEVEL  = 3'd7;

  localparam logic [15:0] SHORT_HYST_MV = 16'd1000;

  typedef enum logic [2:0] {
    CH_OFF   = 3'b001,
    CH_ON    = 3'b010,
    CH_LATCH = 3'b100
  } chan_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        request_on;
    logic [15:0] load_current_ma;
    logic [15:0] output_mv;
    logic [15:0] battery_mv;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       drive_on;
    logic       latched;
    logic       in_error;
    logic [2:0] diag_status;
    logic [7:0] retries_used;
  } result_t;

  typedef struct packed {
    logic        oc_enable;
    logic [15:0] oc_threshold_ma;
    logic [15:0] oc_trip_limit;
    logic [7:0]  retry_limit;
    logic [15:0] retry_delay_ms;
    logic [1:0]  error_behavior;
    logic [15:0] open_load_ma;
    logic [15:0] fault_level_ma;
  } cfg_t;

  typedef struct packed {
    chan_t       chan;
    logic        error_flag;
    logic [15:0] trip_count;
    logic [7:0]  retry_count;
    logic        timer_running;
    logic [15:0] timer_left;
    logic [2:0]  status;
  } guard_state_t;

endpackage

FILE: src/load_switch_overcurrent_guard_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_switch_overcurrent_guard_core
// Overcurrent guard with retry and latch-off for one power-switch channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one item: a set
//   command, a current/voltage sample or a one millisecond tick. Every item
//   gives exactly one result on the output channel (out_valid / out_stall /
//   out_item) with the command outcome and the channel status after it.
//   An item is registered on entry, evaluated against the guard state once the
//   result register is free, and its result is registered; out_valid holds
//   until the receiver takes the result. Throughput is one item per cycle
//   while out_stall is low, set by the combinational compare and counter
//   update on the guard state.
//   When the receiver stalls, the result register holds and the input stage
//   holds its item; in_stall rises once both are full.
//   Configuration registers are written through cfg_valid / cfg_ready with
//   cfg_index and cfg_data; write only while no item is in flight.
//   Synchronous reset clears the pipeline, sets the channel off with no
//   error, and loads the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module load_switch_overcurrent_guard_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lsog_pkg::item_t   in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output lsog_pkg::result_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import lsog_pkg::*;

  cfg_t         cfg;
  guard_state_t st_r;
  guard_state_t st_nxt;
  item_t        item_r;
  logic         item_v_r;
  result_t      res_nxt;
  result_t      res_r;
  logic         res_v_r;
  logic         advance;

  lsog_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsog_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // move the held item into the result register when it is free
  assign advance   = item_v_r && (!res_v_r || !out_stall);
  assign in_stall  = item_v_r && !advance;
  assign out_valid = res_v_r;
  assign out_item  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      res_v_r  <= 1'b0;
      st_r.chan          <= CH_OFF;
      st_r.error_flag    <= 1'b0;
      st_r.trip_count    <= 16'd0;
      st_r.retry_count   <= 8'd0;
      st_r.timer_running <= 1'b0;
      st_r.timer_left    <= 16'd0;
      st_r.status        <= ST_OFF;
    end else begin
      if (in_valid && !in_stall) begin
        item_v_r <= 1'b1;
      end else if (advance) begin
        item_v_r <= 1'b0;
      end
      if (advance) begin
        res_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (!out_stall) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  a_timer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.timer_running |-> (st_r.timer_left != 16'd0))
    else $error("retry timer running with zero ticks left");

  a_error_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.error_flag && !st_r.timer_running) |-> (st_r.chan == CH_LATCH))
    else $error("error flag set without timer or latch");

  a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.chan == CH_LATCH) |=> (st_r.chan == CH_LATCH))
    else $error("latched channel left latch state");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_v_r) |-> $past(item_v_r))
    else $error("result appeared without a held item");

endmodule

FILE: src/lsog_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsog_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module lsog_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output lsog_pkg::cfg_t cfg
);
  import lsog_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oc_enable       <= 1'b1;
      cfg_r.oc_threshold_ma <= 16'd10000;
      cfg_r.oc_trip_limit   <= 16'd1000;
      cfg_r.retry_limit     <= 8'd3;
      cfg_r.retry_delay_ms  <= 16'd1000;
      cfg_r.error_behavior  <= BEH_RETRY;
      cfg_r.open_load_ma    <= 16'd100;
      cfg_r.fault_level_ma  <= 16'd12000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OC_ENABLE:    cfg_r.oc_enable       <= cfg_data[0];
        REG_OC_THRESHOLD: cfg_r.oc_threshold_ma <= cfg_data;
        REG_OC_TRIP:      cfg_r.oc_trip_limit   <= cfg_data;
        REG_RETRY_LIMIT:  cfg_r.retry_limit     <= cfg_data[7:0];
        REG_RETRY_DELAY:  cfg_r.retry_delay_ms  <= cfg_data;
        REG_ERR_BEHAVIOR: cfg_r.error_behavior  <= cfg_data[1:0];
        REG_OPEN_LOAD:    cfg_r.open_load_ma    <= cfg_data;
        REG_FAULT_LEVEL:  cfg_r.fault_level_ma  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/lsog_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsog_step
// Next-state and result logic for one item: command, sample or tick.
// ----------------------------------------------------------------------------
module lsog_step (
  input  lsog_pkg::cfg_t         cfg,
  input  lsog_pkg::guard_state_t st,
  input  lsog_pkg::item_t        item,
  output lsog_pkg::guard_state_t st_nxt,
  output lsog_pkg::result_t      res
);
  import lsog_pkg::*;

  logic        acc;
  logic        soft_oc;
  logic [2:0]  hw;
  logic [2:0]  status_new;
  logic [15:0] diff;
  logic [15:0] tleft_dec;
  chan_t       chan_off;

  always_comb begin
    if (item.battery_mv >= item.output_mv) begin
      diff = item.battery_mv - item.output_mv;
    end else begin
      diff = item.output_mv - item.battery_mv;
    end

    // hardware classification of the channel from this sample
    hw = ST_OFF;
    if (st.chan == CH_OFF) begin
      if ((item.load_current_ma >= cfg.fault_level_ma) && (diff < SHORT_HYST_MV)) begin
        hw = ST_SHORT;
      end
    end else if (item.load_current_ma >= cfg.fault_level_ma) begin
      hw = ST_OFF;
    end else if (item.load_current_ma <= cfg.open_load_ma) begin
      hw = ST_OPEN;
    end else if (item.output_mv <= item.battery_mv) begin
      hw = ST_ON;
    end

    soft_oc = cfg.oc_enable && (item.load_current_ma > cfg.oc_threshold_ma) &&
              (st.trip_count >= cfg.oc_trip_limit);
    status_new = soft_oc ? ST_SOFT_OC : hw;
    tleft_dec  = (st.timer_left != 16'd0) ? st.timer_left - 16'd1 : 16'd0;
    chan_off   = (st.chan == CH_LATCH) ? CH_LATCH : CH_OFF;

    st_nxt = st;
    acc    = 1'b1;

    unique case (item.action)
      ACT_SET: begin
        if (st.chan == CH_LATCH) begin
          acc = 1'b0;
        end else if (st.error_flag && item.request_on) begin
          acc = 1'b0;
        end else begin
          st_nxt.chan = item.request_on ? CH_ON : CH_OFF;
        end
      end
      ACT_SAMPLE: begin
        if (cfg.oc_enable && (item.load_current_ma > cfg.oc_threshold_ma)) begin
          if (soft_oc) begin
            st_nxt.trip_count = 16'd0;
          end else if (st.chan == CH_ON) begin
            st_nxt.trip_count = st.trip_count + 16'd1;
          end
        end
        st_nxt.status = status_new;
        // react only on entry into soft overcurrent
        if (soft_oc && (st.status != ST_SOFT_OC)) begin
          if (cfg.error_behavior == BEH_LATCH) begin
            if (st.chan != CH_LATCH) begin
              st_nxt.chan   = CH_LATCH;
              st_nxt.status = ST_LATCHED;
            end
          end else if (cfg.error_behavior == BEH_RETRY) begin
            st_nxt.chan = chan_off;
            if (st.retry_count >= cfg.retry_limit) begin
              st_nxt.timer_running = 1'b0;
              st_nxt.timer_left    = 16'd0;
              st_nxt.error_flag    = 1'b1;
              if (st.chan != CH_LATCH) begin
                st_nxt.chan   = CH_LATCH;
                st_nxt.status = ST_LATCHED;
              end
            end else begin
              if (!st.timer_running) begin
                st_nxt.timer_running = 1'b1;
                st_nxt.timer_left    = (cfg.retry_delay_ms == 16'd0) ? 16'd1
                                                                     : cfg.retry_delay_ms;
                st_nxt.error_flag    = 1'b1;
              end
              st_nxt.retry_count = st.retry_count + 8'd1;
            end
          end
        end
      end
      ACT_TICK: begin
        if (st.timer_running) begin
          st_nxt.timer_left = tleft_dec;
          if (tleft_dec == 16'd0) begin
            // clear the error first so the retry switch-on goes through
            st_nxt.timer_running = 1'b0;
            st_nxt.error_flag    = 1'b0;
            if (st.chan != CH_LATCH) begin
              st_nxt.chan = CH_ON;
            end
          end
        end
      end
      default: ;
    endcase

    res.accepted     = acc;
    res.drive_on     = (st_nxt.chan == CH_ON);
    res.latched      = (st_nxt.chan == CH_LATCH);
    res.in_error     = st_nxt.error_flag;
    res.diag_status  = st_nxt.status;
    res.retries_used = st_nxt.retry_count;
  end

endmodule
